// ===== hw/rtl/rcc_pkg.sv =====
package rcc_pkg;

  // width of the size registers and the position counters
  localparam int CNT_W = 11;
  localparam int MAX_HEIGHT = 1024;
  // radius times width plus radius
  localparam int LAG_W = CNT_W + 3;
  localparam int RAD_W = 3;
  localparam int CH_W = 8;
  localparam int CH_N = 3;
  localparam int PIX_W = CH_W * CH_N;
  localparam int CH_MAX = 255;
  localparam int POS_W = 10;

  typedef enum logic [1:0] {
    CMD_LOAD  = 2'd0,
    CMD_PIXEL = 2'd1,
    CMD_FLUSH = 2'd2
  } cmd_e;

  typedef enum logic [1:0] {
    CFG_WIDTH  = 2'd0,
    CFG_HEIGHT = 2'd1,
    CFG_RADIUS = 2'd2
  } cfg_idx_e;

endpackage

// ===== hw/rtl/rgb_convolution_clamped_unit.sv =====
// Streaming convolution of a blue-green-red pixel stream with a square signed
// kernel of side 2R+1 and zero padding; each channel is filtered on its own and
// clamped to 0..255. Results leave in raster order R*W+R words behind the input;
// once the last pixel is in, each flush word drains one result. The block takes
// one word per cycle unless stalled: per-line buffers with one read and one
// write port feed a window register, three channel lanes multiply all taps at
// once, and a result passes stage 1, the product and row-sum registers and the
// output register. If an image holds fewer than R*W+R pixels, the block
// shifts in zero padding for the missing lead after the last pixel, holding input.
// Size writes restart the frame and must come while the block is idle.
module rgb_convolution_clamped_unit #(
  parameter int MAX_KERNEL = 5,
  parameter int MAX_WIDTH  = 1024,
  parameter int TAP_BITS   = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [1:0]         cfg_index_i,
  input  logic [10:0]        cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [1:0]         command_i,
  input  logic [2:0]         tap_row_i,
  input  logic [2:0]         tap_col_i,
  input  logic signed [15:0] tap_value_i,
  input  logic [7:0]         in_blue_i,
  input  logic [7:0]         in_green_i,
  input  logic [7:0]         in_red_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [7:0]         out_blue_o,
  output logic [7:0]         out_green_o,
  output logic [7:0]         out_red_o,
  output logic [9:0]         out_row_o,
  output logic [9:0]         out_col_o,
  output logic               frame_last_o
);

  localparam int K = MAX_KERNEL;
  localparam int AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int KIW = (K > 1) ? $clog2(K) : 1;
  localparam int RMAX = (K - 1) / 2;
  localparam int CW = rcc_pkg::CNT_W;

  // size registers
  logic [CW-1:0] width_q, height_q;
  logic [1:0]    radius_q;
  logic [CW-1:0] w_eff, h_eff;
  logic [rcc_pkg::RAD_W-1:0] r_eff;
  logic [rcc_pkg::LAG_W-1:0] lag;
  logic          cfg_we;

  // position counters
  logic [CW-1:0] in_row_q, in_row_d, col_q, col_d, er_q, er_d, ec_q, ec_d;
  logic [rcc_pkg::LAG_W-1:0] lead_q, lead_d;

  // accept side decode
  logic accept, is_pix, is_flush, is_load;
  logic s0_shift, s0_emit, s0_load, s0_last, col_wrap;
  logic pad, pad_fire;

  // pipeline control
  logic out_ready, s3_free, s2_free, s1_free, s1_fire;
  logic s1v_q, s2v_q, s3v_q, ov_q;

  // stage 1 payload
  logic                      s1_shift_q, s1_emit_q, s1_load_q, s1_last_q;
  logic [AW-1:0]             s1_col_q;
  logic [rcc_pkg::PIX_W-1:0] s1_pix_q;
  logic [CW-1:0]             s1_er_q, s1_ec_q;
  logic [2:0]                s1_tr_q, s1_tc_q;
  logic signed [TAP_BITS-1:0] s1_tv_q;

  // later stage tags
  logic [CW-1:0] s2_row_q, s2_col_q, s3_row_q, s3_col_q;
  logic          s2_last_q, s3_last_q;

  // output register
  logic [rcc_pkg::CH_W-1:0]  out_b_q, out_g_q, out_r_q;
  logic [rcc_pkg::POS_W-1:0] out_row_q, out_col_q;
  logic                      out_last_q;

  logic signed [TAP_BITS-1:0] tap_q [K][K];
  logic [rcc_pkg::PIX_W-1:0]  win [K][K];
  logic [rcc_pkg::PIX_W-1:0]  sel_pix [K][K];
  logic [rcc_pkg::CH_W-1:0]   lane_res [rcc_pkg::CH_N];

  assign cfg_ready_o = 1'b1;
  assign cfg_we = cfg_valid_i && (cfg_index_i == rcc_pkg::CFG_WIDTH ||
                                  cfg_index_i == rcc_pkg::CFG_HEIGHT ||
                                  cfg_index_i == rcc_pkg::CFG_RADIUS);

  always_comb begin
    priority if (width_q == '0) begin
      w_eff = CW'(1);
    end else if (int'(width_q) > MAX_WIDTH) begin
      w_eff = CW'(MAX_WIDTH);
    end else begin
      w_eff = width_q;
    end
    priority if (height_q == '0) begin
      h_eff = CW'(1);
    end else if (int'(height_q) > rcc_pkg::MAX_HEIGHT) begin
      h_eff = CW'(rcc_pkg::MAX_HEIGHT);
    end else begin
      h_eff = height_q;
    end
    if (int'(radius_q) > RMAX) begin
      r_eff = rcc_pkg::RAD_W'(RMAX);
    end else begin
      r_eff = rcc_pkg::RAD_W'(radius_q);
    end
  end

  assign lag = rcc_pkg::LAG_W'(r_eff) * rcc_pkg::LAG_W'(w_eff) + rcc_pkg::LAG_W'(r_eff);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= CW'(1024);
      height_q <= CW'(1024);
      radius_q <= 2'd1;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        rcc_pkg::CFG_WIDTH:  width_q  <= cfg_data_i;
        rcc_pkg::CFG_HEIGHT: height_q <= cfg_data_i;
        rcc_pkg::CFG_RADIUS: radius_q <= cfg_data_i[1:0];
        default: ;
      endcase
    end
  end

  // short image drained before the lead is full: shift in zero words first
  assign pad      = (in_row_q >= h_eff) && (lead_q < lag);
  assign pad_fire = pad && s1_free;

  // pipeline flow
  assign out_ready = !ov_q || !out_stall_i;
  assign s3_free   = !s3v_q || out_ready;
  assign s2_free   = !s2v_q || s3_free;
  assign s1_free   = !s1v_q || !s1_emit_q || s2_free;
  assign s1_fire   = s1v_q && s1_free;
  assign in_stall_o = !s1_free || pad;
  assign accept    = in_valid_i && s1_free && !pad;

  always_comb begin
    is_pix   = command_i == rcc_pkg::CMD_PIXEL;
    is_flush = command_i == rcc_pkg::CMD_FLUSH;
    is_load  = command_i == rcc_pkg::CMD_LOAD;
    s0_shift = (is_pix && in_row_q < h_eff) || (is_flush && in_row_q >= h_eff);
    s0_emit  = (is_pix && in_row_q < h_eff && lead_q >= lag) ||
               (is_flush && in_row_q >= h_eff);
    s0_load  = is_load && int'(tap_row_i) < K && int'(tap_col_i) < K;
    s0_last  = s0_emit && (er_q + CW'(1) == h_eff) && (ec_q + CW'(1) == w_eff);
    col_wrap = (col_q + CW'(1)) >= w_eff;
  end

  always_comb begin
    in_row_d = in_row_q;
    col_d    = col_q;
    er_d     = er_q;
    ec_d     = ec_q;
    lead_d   = lead_q;
    if (cfg_we) begin
      in_row_d = '0;
      col_d    = '0;
      er_d     = '0;
      ec_d     = '0;
      lead_d   = '0;
    end else if (pad_fire) begin
      col_d  = col_wrap ? '0 : col_q + CW'(1);
      lead_d = lead_q + rcc_pkg::LAG_W'(1);
    end else if (accept) begin
      if (s0_shift) begin
        col_d = col_wrap ? '0 : col_q + CW'(1);
        if (is_pix && col_wrap) begin
          in_row_d = in_row_q + CW'(1);
        end
        if (is_pix && !s0_emit) begin
          lead_d = lead_q + rcc_pkg::LAG_W'(1);
        end
      end
      if (s0_emit) begin
        if (ec_q + CW'(1) >= w_eff) begin
          ec_d = '0;
          er_d = er_q + CW'(1);
        end else begin
          ec_d = ec_q + CW'(1);
        end
      end
      // end of frame: everything starts over
      if (s0_last) begin
        in_row_d = '0;
        col_d    = '0;
        er_d     = '0;
        ec_d     = '0;
        lead_d   = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_row_q <= '0;
      col_q    <= '0;
      er_q     <= '0;
      ec_q     <= '0;
      lead_q   <= '0;
    end else begin
      in_row_q <= in_row_d;
      col_q    <= col_d;
      er_q     <= er_d;
      ec_q     <= ec_d;
      lead_q   <= lead_d;
    end
  end

  // valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1v_q <= 1'b0;
      s2v_q <= 1'b0;
      s3v_q <= 1'b0;
      ov_q  <= 1'b0;
    end else begin
      if (s1_free) begin
        s1v_q <= accept || pad_fire;
      end
      if (s2_free) begin
        s2v_q <= s1_fire && s1_emit_q;
      end
      if (s3_free) begin
        s3v_q <= s2v_q;
      end
      if (out_ready) begin
        ov_q <= s3v_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept || pad_fire) begin
      s1_shift_q <= s0_shift || pad;
      s1_emit_q  <= s0_emit && !pad;
      s1_load_q  <= s0_load && !pad;
      s1_last_q  <= s0_last && !pad;
      s1_col_q   <= AW'(col_q);
      s1_pix_q   <= (is_pix && !pad) ? {in_red_i, in_green_i, in_blue_i} : '0;
      s1_er_q    <= er_q;
      s1_ec_q    <= ec_q;
      s1_tr_q    <= tap_row_i;
      s1_tc_q    <= tap_col_i;
      s1_tv_q    <= TAP_BITS'(tap_value_i);
    end
    if (s2_free) begin
      s2_row_q  <= s1_er_q;
      s2_col_q  <= s1_ec_q;
      s2_last_q <= s1_last_q;
    end
    if (s3_free) begin
      s3_row_q  <= s2_row_q;
      s3_col_q  <= s2_col_q;
      s3_last_q <= s2_last_q;
    end
    if (out_ready) begin
      out_b_q    <= lane_res[0];
      out_g_q    <= lane_res[1];
      out_r_q    <= lane_res[2];
      out_row_q  <= s3_row_q[rcc_pkg::POS_W-1:0];
      out_col_q  <= s3_col_q[rcc_pkg::POS_W-1:0];
      out_last_q <= s3_last_q;
    end
  end

  // taps change in stage 1 so earlier results keep the old kernel
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < K; i++) begin
        for (int j = 0; j < K; j++) begin
          tap_q[i][j] <= '0;
        end
      end
    end else if (s1_fire && s1_load_q) begin
      tap_q[KIW'(s1_tr_q)][KIW'(s1_tc_q)] <= s1_tv_q;
    end
  end

  rcc_linebuf #(
    .KSIDE    (K),
    .MAX_WIDTH(MAX_WIDTH)
  ) u_linebuf (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .rd_en_i ((accept && s0_shift) || pad_fire),
    .rd_col_i(AW'(col_q)),
    .shift_i (s1_fire && s1_shift_q),
    .wr_col_i(s1_col_q),
    .pix_i   (s1_pix_q),
    .win_o   (win)
  );

  // tap (i,j) sees window column 2R-j, line 2R-i; outside the image reads zero
  always_comb begin
    int rr, cc;
    logic act, in_img;
    logic [KIW-1:0] kk, tt;
    for (int i = 0; i < K; i++) begin
      for (int j = 0; j < K; j++) begin
        act = (i <= 2 * int'(r_eff)) && (j <= 2 * int'(r_eff));
        rr = int'(s1_er_q) + i - int'(r_eff);
        cc = int'(s1_ec_q) + j - int'(r_eff);
        in_img = rr >= 0 && rr < int'(h_eff) && cc >= 0 && cc < int'(w_eff);
        kk = KIW'(2 * int'(r_eff) - j);
        tt = KIW'(2 * int'(r_eff) - i);
        sel_pix[i][j] = (act && in_img) ? win[kk][tt] : '0;
      end
    end
  end

  for (genvar ch = 0; ch < rcc_pkg::CH_N; ch++) begin : g_lane
    logic [rcc_pkg::CH_W-1:0] lane_pix [K][K];

    always_comb begin
      for (int i = 0; i < K; i++) begin
        for (int j = 0; j < K; j++) begin
          lane_pix[i][j] = sel_pix[i][j][rcc_pkg::CH_W*ch +: rcc_pkg::CH_W];
        end
      end
    end

    rcc_lane #(
      .KSIDE(K),
      .TAP_W(TAP_BITS)
    ) u_lane (
      .clk_i    (clk_i),
      .prod_en_i(s2_free),
      .sum_en_i (s3_free),
      .pix_i    (lane_pix),
      .tap_i    (tap_q),
      .res_o    (lane_res[ch])
    );
  end

  assign out_valid_o  = ov_q;
  assign out_blue_o   = out_b_q;
  assign out_green_o  = out_g_q;
  assign out_red_o    = out_r_q;
  assign out_row_o    = out_row_q;
  assign out_col_o    = out_col_q;
  assign frame_last_o = out_last_q;

  a_lead_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    lead_q <= lag)
    else $error("pixel lead beyond output lag");

  a_frame_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && s0_last && !cfg_we |=> er_q == '0 && ec_q == '0 && in_row_q == '0)
    else $error("counters not cleared after last result");

  a_stage_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s2v_q && !s3_free |=> s2v_q)
    else $error("stalled product stage lost its result");

endmodule

// ===== hw/rtl/rcc_ram.sv =====
module rcc_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 1024
) (
  input  logic                                     clk_i,
  input  logic                                     we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                         wdata_i,
  input  logic                                     re_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hw/rtl/rcc_linebuf.sv =====
module rcc_linebuf #(
  parameter int KSIDE = 5,
  parameter int MAX_WIDTH = 1024
) (
  input  logic                                           clk_i,
  input  logic                                           rst_ni,
  input  logic                                           rd_en_i,
  input  logic [((MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1)-1:0] rd_col_i,
  input  logic                                           shift_i,
  input  logic [((MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1)-1:0] wr_col_i,
  input  logic [rcc_pkg::PIX_W-1:0]                      pix_i,
  output logic [rcc_pkg::PIX_W-1:0]                      win_o [KSIDE][KSIDE]
);

  // window column k holds the k-th latest word, line t is t rows above it
  logic [rcc_pkg::PIX_W-1:0] win_q [KSIDE][KSIDE];
  logic [rcc_pkg::PIX_W-1:0] win_d [KSIDE][KSIDE];
  logic [rcc_pkg::PIX_W-1:0] mem_rd [KSIDE];
  logic [rcc_pkg::PIX_W-1:0] sample [KSIDE];
  logic [rcc_pkg::PIX_W-1:0] fwd_data_q [KSIDE];
  logic                      fwd_q;
  logic                      fwd_d;

  assign mem_rd[0] = '0;

  for (genvar t = 1; t < KSIDE; t++) begin : g_line
    rcc_ram #(
      .WIDTH(rcc_pkg::PIX_W),
      .DEPTH(MAX_WIDTH)
    ) u_ram (
      .clk_i  (clk_i),
      .we_i   (shift_i),
      .waddr_i(wr_col_i),
      .wdata_i(sample[t-1]),
      .re_i   (rd_en_i),
      .raddr_i(rd_col_i),
      .rdata_o(mem_rd[t])
    );
  end

  // read and write of the same column in one cycle: take the written data
  assign fwd_d = shift_i && (rd_col_i == wr_col_i);

  always_comb begin
    for (int t = 0; t < KSIDE; t++) begin
      if (t == 0) begin
        sample[t] = pix_i;
      end else if (fwd_q) begin
        sample[t] = fwd_data_q[t];
      end else begin
        sample[t] = mem_rd[t];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_q <= 1'b0;
    end else if (rd_en_i) begin
      fwd_q <= fwd_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      for (int t = 0; t < KSIDE; t++) begin
        fwd_data_q[t] <= (t == 0) ? '0 : sample[(t > 0) ? t - 1 : 0];
      end
    end
  end

  always_comb begin
    for (int k = 0; k < KSIDE; k++) begin
      for (int t = 0; t < KSIDE; t++) begin
        if (!shift_i) begin
          win_d[k][t] = win_q[k][t];
        end else if (k == 0) begin
          win_d[k][t] = sample[t];
        end else begin
          win_d[k][t] = win_q[(k > 0) ? k - 1 : 0][t];
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < KSIDE; k++) begin
        for (int t = 0; t < KSIDE; t++) begin
          win_q[k][t] <= '0;
        end
      end
    end else begin
      win_q <= win_d;
    end
  end

  assign win_o = win_d;

endmodule

// ===== hw/rtl/rcc_lane.sv =====
module rcc_lane #(
  parameter int KSIDE = 5,
  parameter int TAP_W = 16
) (
  input  logic                     clk_i,
  input  logic                     prod_en_i,
  input  logic                     sum_en_i,
  input  logic [rcc_pkg::CH_W-1:0] pix_i [KSIDE][KSIDE],
  input  logic signed [TAP_W-1:0]  tap_i [KSIDE][KSIDE],
  output logic [rcc_pkg::CH_W-1:0] res_o
);

  localparam int PW = TAP_W + rcc_pkg::CH_W + 1;
  localparam int RW = PW + $clog2(KSIDE) + 1;
  localparam int TW = RW + $clog2(KSIDE) + 1;

  logic signed [PW-1:0] prod_d [KSIDE][KSIDE];
  logic signed [PW-1:0] prod_q [KSIDE][KSIDE];
  logic signed [RW-1:0] row_d [KSIDE];
  logic signed [RW-1:0] row_q [KSIDE];
  logic signed [TW-1:0] total;

  always_comb begin
    for (int i = 0; i < KSIDE; i++) begin
      for (int j = 0; j < KSIDE; j++) begin
        prod_d[i][j] = $signed({1'b0, pix_i[i][j]}) * tap_i[i][j];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (prod_en_i) begin
      prod_q <= prod_d;
    end
  end

  always_comb begin
    for (int i = 0; i < KSIDE; i++) begin
      row_d[i] = '0;
      for (int j = 0; j < KSIDE; j++) begin
        row_d[i] = row_d[i] + RW'(prod_q[i][j]);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (sum_en_i) begin
      row_q <= row_d;
    end
  end

  always_comb begin
    total = '0;
    for (int i = 0; i < KSIDE; i++) begin
      total = total + TW'(row_q[i]);
    end
  end

  always_comb begin
    priority if (total < 0) begin
      res_o = '0;
    end else if (total > rcc_pkg::CH_MAX) begin
      res_o = rcc_pkg::CH_W'(rcc_pkg::CH_MAX);
    end else begin
      res_o = total[rcc_pkg::CH_W-1:0];
    end
  end

endmodule
